>>> rtl/core/ty86_pkg.sv
`timescale 1ns / 1ps
// ty86_pkg: shared types and constants of the tiny Y86 subset execute block.
// Depends on nothing; used by ty86_front, ty86_back and the top level.
package ty86_pkg;

  // Input word: one decoded instruction.
  typedef struct packed {
    logic [3:0]        mode;
    logic [2:0]        src_reg;
    logic [2:0]        dst_reg;
    logic signed [7:0] immediate;
    logic [2:0]        base_reg;
    logic signed [7:0] mem_offset;
    logic [7:0]        branch_target;
  } in_word_t;

  // Result word: architectural state after the instruction.
  typedef struct packed {
    logic [7:0]        next_pc;
    logic              halted;
    logic              fault;
    logic              zero_flag;
    logic              sign_flag;
    logic              overflow_flag;
    logic signed [7:0] written_value;
    logic              address_warning;
  } out_word_t;

  // Opcodes; every code above OP_MRMOV is illegal and maps to OP_BAD.
  typedef enum logic [3:0] {
    OP_HALT  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_CMP   = 4'd3,
    OP_JE    = 4'd4,
    OP_JNE   = 4'd5,
    OP_JG    = 4'd6,
    OP_JL    = 4'd7,
    OP_RRMOV = 4'd8,
    OP_IRMOV = 4'd9,
    OP_RMMOV = 4'd10,
    OP_MRMOV = 4'd11,
    OP_BAD   = 4'd12
  } op_t;

  // Classified instruction as it sits in the decode queue.
  typedef struct packed {
    op_t      op;
    logic     b_sel_base;  // second read port takes base_reg instead of dst_reg
    in_word_t raw;
  } dec_word_t;

  // Decode queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Effective address is (base + offset) masked to ADDR_W bits (mask 0xf).
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned ADDR_SPAN = 2 ** ADDR_W;

  // Register index fields are 3 bits wide.
  localparam int unsigned RIDX_SPAN = 8;
  // Branch target field is 8 bits wide.
  localparam int unsigned TGT_SPAN  = 256;

endpackage

>>> rtl/core/tiny_y86_subset_execute.sv
`timescale 1ns / 1ps
// tiny_y86_subset_execute: top level of the Y86 subset execute block.
// Depends on ty86_pkg, ty86_front and ty86_back.
//
//   channel   ports                         word type
//   input     in_push / in_full / in_word   ty86_pkg::in_word_t
//   result    out_empty / out_pop / out_word ty86_pkg::out_word_t
//
// Sustains one instruction word per cycle in and one result word per cycle out
// while the result side pops every cycle. A pushed word is written into the
// decode queue, read from the register file through its registered read port
// into the execute stage, and its result is registered into out_word.
// rst_n is synchronous: registers, flags, data memory, PC and halt mark clear.
// A stalled result side backs up the execute stage, then the 4-word decode
// queue, then raises in_full; the result register lets execute keep going
// while an earlier result is still being taken.
module tiny_y86_subset_execute #(
  parameter int unsigned PROGRAM_DEPTH = 256,
  parameter int unsigned REG_COUNT     = 8,
  parameter int unsigned MEM_DEPTH     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ty86_pkg::in_word_t  in_word,
  output logic                out_empty,
  input  logic                out_pop,
  output ty86_pkg::out_word_t out_word
);

  // Decode queue between front and back.
  logic                q_valid;
  logic                q_pop;
  ty86_pkg::dec_word_t q_word;

  // Front: takes words, classifies the opcode, queues them.
  ty86_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_word  (q_word)
  );

  // Back: register read, execute, state update and result register.
  ty86_back #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .REG_COUNT     (REG_COUNT),
    .MEM_DEPTH     (MEM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_word    (q_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

>>> rtl/core/ty86_front.sv
`timescale 1ns / 1ps
// ty86_front: accepts instruction words, classifies the opcode and queues them.
// Depends on ty86_pkg.
module ty86_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ty86_pkg::in_word_t  in_word,
  output logic                q_valid,
  input  logic                q_pop,
  output ty86_pkg::dec_word_t q_word
);

  ty86_pkg::dec_word_t               dec;
  ty86_pkg::dec_word_t               q_mem [ty86_pkg::QDEPTH];
  logic [ty86_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [ty86_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              push, pop;

  // Opcode classification.
  always_comb begin
    dec            = '0;
    dec.raw        = in_word;
    dec.op         = ty86_pkg::OP_BAD;
    dec.b_sel_base = 1'b0;
    unique case (in_word.mode)
      ty86_pkg::OP_HALT:  dec.op = ty86_pkg::OP_HALT;
      ty86_pkg::OP_ADD:   dec.op = ty86_pkg::OP_ADD;
      ty86_pkg::OP_SUB:   dec.op = ty86_pkg::OP_SUB;
      ty86_pkg::OP_CMP:   dec.op = ty86_pkg::OP_CMP;
      ty86_pkg::OP_JE:    dec.op = ty86_pkg::OP_JE;
      ty86_pkg::OP_JNE:   dec.op = ty86_pkg::OP_JNE;
      ty86_pkg::OP_JG:    dec.op = ty86_pkg::OP_JG;
      ty86_pkg::OP_JL:    dec.op = ty86_pkg::OP_JL;
      ty86_pkg::OP_RRMOV: dec.op = ty86_pkg::OP_RRMOV;
      ty86_pkg::OP_IRMOV: dec.op = ty86_pkg::OP_IRMOV;
      ty86_pkg::OP_RMMOV: begin
        dec.op         = ty86_pkg::OP_RMMOV;
        dec.b_sel_base = 1'b1;
      end
      ty86_pkg::OP_MRMOV: begin
        dec.op         = ty86_pkg::OP_MRMOV;
        dec.b_sel_base = 1'b1;
      end
      default:            dec.op = ty86_pkg::OP_BAD;
    endcase
  end

  assign in_full = (cnt_r == ty86_pkg::QCNT_W'(ty86_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign push    = in_push && !in_full;
  assign pop     = q_pop && q_valid;
  assign q_word  = q_mem[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + ty86_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - ty86_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + ty86_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + ty86_pkg::QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= dec;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ty86_pkg::QCNT_W'(ty86_pkg::QDEPTH))
    else $error("decode queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r != '0))
    else $error("decode queue popped while empty");

endmodule

>>> rtl/core/ty86_back.sv
`timescale 1ns / 1ps
// ty86_back: register file read, execute, flags, PC, data memory and result register.
// Depends on ty86_pkg.
module ty86_back #(
  parameter int unsigned PROGRAM_DEPTH = 256,
  parameter int unsigned REG_COUNT     = 8,
  parameter int unsigned MEM_DEPTH     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  ty86_pkg::dec_word_t q_word,
  output logic                out_empty,
  input  logic                out_pop,
  output ty86_pkg::out_word_t out_word
);

  localparam int unsigned RIW = $clog2(REG_COUNT);
  localparam int unsigned PCW = $clog2(PROGRAM_DEPTH);
  // Addresses never exceed the mask, so entries beyond it are never touched.
  localparam int unsigned MEM_ENTRIES =
    (MEM_DEPTH < ty86_pkg::ADDR_SPAN) ? MEM_DEPTH : ty86_pkg::ADDR_SPAN;
  localparam int unsigned MAW = $clog2(MEM_ENTRIES);
  localparam logic signed [9:0] WARN_LIM = 10'(MEM_DEPTH - 1);

  // Constant remap tables for index fields that may exceed the storage.
  logic [RIW-1:0] reg_map  [ty86_pkg::RIDX_SPAN];
  logic [PCW-1:0] tgt_map  [ty86_pkg::TGT_SPAN];
  logic [MAW-1:0] addr_map [ty86_pkg::ADDR_SPAN];

  for (genvar g = 0; g < ty86_pkg::RIDX_SPAN; g++) begin : g_reg_map
    assign reg_map[g] = RIW'(g % REG_COUNT);
  end
  for (genvar g = 0; g < ty86_pkg::TGT_SPAN; g++) begin : g_tgt_map
    assign tgt_map[g] = PCW'(g % PROGRAM_DEPTH);
  end
  for (genvar g = 0; g < ty86_pkg::ADDR_SPAN; g++) begin : g_addr_map
    assign addr_map[g] = MAW'(g % MEM_ENTRIES);
  end

  // Register file: two registered read ports, one write port.
  logic signed [7:0]   rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic                rf_we;
  logic [RIW-1:0]      rf_waddr;
  logic signed [7:0]   rf_wdata;

  // Data memory and architectural state.
  logic signed [7:0] dm_r [MEM_ENTRIES];
  logic              dm_we;
  logic [PCW-1:0]    pc_r, pc_nxt, pc_inc;
  logic              halt_r, halt_nxt;
  logic              zf_r, zf_nxt, sf_r, sf_nxt, of_r, of_nxt;

  // Execute stage.
  logic              ex_v_r;
  ty86_pkg::op_t     ex_op_r;
  logic [RIW-1:0]    ex_rd_r;
  logic signed [7:0] ex_imm_r, ex_off_r;
  logic [PCW-1:0]    ex_tgt_r;
  logic signed [7:0] a_r, b_r;

  logic              ex_fire, ex_load;
  logic [RIW-1:0]    ld_rs, ld_b;
  logic signed [9:0] sum;
  logic [MAW-1:0]    mem_addr;
  logic signed [7:0] alu_add, alu_sub, wval;
  logic              warn, fault;

  logic                out_v_r;
  ty86_pkg::out_word_t out_word_r;
  logic [PCW+7:0]      pc_ext;

  assign ex_fire   = ex_v_r && (!out_v_r || out_pop);
  assign ex_load   = q_valid && (!ex_v_r || ex_fire);
  assign q_pop     = ex_load;
  assign out_empty = !out_v_r;
  assign out_word  = out_word_r;

  assign ld_rs = reg_map[q_word.raw.src_reg];
  assign ld_b  = q_word.b_sel_base ? reg_map[q_word.raw.base_reg]
                                   : reg_map[q_word.raw.dst_reg];

  // Register read with write-first bypass from the instruction retiring now.
  always_ff @(posedge clk) begin
    if (ex_load) begin
      if (rf_we && (rf_waddr == ld_rs))
        a_r <= rf_wdata;
      else
        a_r <= rf_vld_r[ld_rs] ? rf_mem[ld_rs] : 8'sd0;
      if (rf_we && (rf_waddr == ld_b))
        b_r <= rf_wdata;
      else
        b_r <= rf_vld_r[ld_b] ? rf_mem[ld_b] : 8'sd0;
      ex_op_r  <= q_word.op;
      ex_rd_r  <= reg_map[q_word.raw.dst_reg];
      ex_imm_r <= q_word.raw.immediate;
      ex_off_r <= q_word.raw.mem_offset;
      ex_tgt_r <= tgt_map[q_word.raw.branch_target];
    end
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
  end

  // Execute.
  assign sum      = 10'(b_r) + 10'(ex_off_r);
  assign mem_addr = addr_map[sum[ty86_pkg::ADDR_W-1:0]];
  assign alu_add  = b_r + a_r;
  assign alu_sub  = b_r - a_r;
  assign pc_inc   = (pc_r == PCW'(PROGRAM_DEPTH - 1)) ? '0 : pc_r + PCW'(1);

  always_comb begin
    pc_nxt   = pc_inc;
    halt_nxt = halt_r;
    zf_nxt   = zf_r;
    sf_nxt   = sf_r;
    of_nxt   = of_r;
    wval     = 8'sd0;
    warn     = 1'b0;
    fault    = 1'b0;
    rf_we    = 1'b0;
    dm_we    = 1'b0;
    if (halt_r) begin
      pc_nxt = pc_r;
    end else begin
      unique case (ex_op_r)
        ty86_pkg::OP_HALT: begin
          halt_nxt = 1'b1;
          pc_nxt   = pc_r;
        end
        ty86_pkg::OP_ADD: begin
          wval  = alu_add;
          rf_we = 1'b1;
        end
        ty86_pkg::OP_SUB: begin
          wval  = alu_sub;
          rf_we = 1'b1;
        end
        ty86_pkg::OP_CMP: begin
          zf_nxt = (alu_sub == 8'sd0);
          sf_nxt = alu_sub[7];
          of_nxt = (b_r[7] ^ a_r[7]) & (b_r[7] ^ alu_sub[7]);
        end
        ty86_pkg::OP_JE:  if (zf_r) pc_nxt = ex_tgt_r;
        ty86_pkg::OP_JNE: if (!zf_r) pc_nxt = ex_tgt_r;
        ty86_pkg::OP_JG:  if (!(sf_r ^ of_r) && !zf_r) pc_nxt = ex_tgt_r;
        ty86_pkg::OP_JL:  if (sf_r ^ of_r) pc_nxt = ex_tgt_r;
        ty86_pkg::OP_RRMOV: begin
          wval  = a_r;
          rf_we = 1'b1;
        end
        ty86_pkg::OP_IRMOV: begin
          wval  = ex_imm_r;
          rf_we = 1'b1;
        end
        ty86_pkg::OP_RMMOV: begin
          wval  = a_r;
          dm_we = 1'b1;
          warn  = (sum > WARN_LIM);
        end
        ty86_pkg::OP_MRMOV: begin
          wval  = dm_r[mem_addr];
          rf_we = 1'b1;
          warn  = (sum > WARN_LIM);
        end
        default: begin
          halt_nxt = 1'b1;
          fault    = 1'b1;
          pc_nxt   = pc_r;
        end
      endcase
    end
    rf_we = rf_we && ex_fire;
    dm_we = dm_we && ex_fire;
  end

  assign rf_waddr = ex_rd_r;
  assign rf_wdata = wval;
  assign pc_ext   = {8'b0, pc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      pc_r     <= '0;
      halt_r   <= 1'b0;
      zf_r     <= 1'b0;
      sf_r     <= 1'b0;
      of_r     <= 1'b0;
      ex_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < MEM_ENTRIES; i++) dm_r[i] <= 8'sd0;
    end else begin
      if (rf_we) rf_vld_r[rf_waddr] <= 1'b1;
      if (dm_we) dm_r[mem_addr] <= wval;
      if (ex_fire) begin
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
        zf_r   <= zf_nxt;
        sf_r   <= sf_nxt;
        of_r   <= of_nxt;
      end
      if (ex_load)      ex_v_r <= 1'b1;
      else if (ex_fire) ex_v_r <= 1'b0;
      if (ex_fire)      out_v_r <= 1'b1;
      else if (out_pop) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_word_r.next_pc         <= pc_ext[7:0];
      out_word_r.halted          <= halt_nxt;
      out_word_r.fault           <= fault;
      out_word_r.zero_flag       <= zf_nxt;
      out_word_r.sign_flag       <= sf_nxt;
      out_word_r.overflow_flag   <= of_nxt;
      out_word_r.written_value   <= wval;
      out_word_r.address_warning <= warn;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt mark dropped without reset");

  a_halted_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && halt_r) |=> $stable(pc_r))
    else $error("program counter moved while halted");

  a_flags_cmp_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && (ex_op_r != ty86_pkg::OP_CMP)) |=> $stable({zf_r, sf_r, of_r}))
    else $error("flags changed by an instruction other than compare");

  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_word_r.fault) |-> out_word_r.halted)
    else $error("faulting word not reported as halted");

endmodule

>>> tb/tiny_y86_subset_execute_test.sv
`timescale 1ns / 1ps
// tiny_y86_subset_execute_test: self-checking testbench of the Y86 subset execute block.
// Depends on ty86_pkg and tiny_y86_subset_execute; predicts every result word in-line.
module tiny_y86_subset_execute_test;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  ty86_pkg::in_word_t  in_word;
  logic                out_empty;
  logic                out_pop;
  ty86_pkg::out_word_t out_word;

  tiny_y86_subset_execute i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  // 4 ns clock; stimulus moves on the falling edge, everything is sampled on the rising edge
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Architectural state as the testbench sees it; mirrors the block's reset values
  logic signed [7:0] arch_reg [ty86_pkg::RIDX_SPAN];
  logic signed [7:0] arch_mem [ty86_pkg::ADDR_SPAN];
  logic [7:0]        arch_pc;
  logic              arch_zf;
  logic              arch_sf;
  logic              arch_of;
  logic              arch_halted;

  ty86_pkg::out_word_t pending_results[$];  // predicted result words, oldest first
  int                  error_count;
  int                  idle_pct;            // chance per cycle that the sender holds off
  int                  stall_pct;           // chance per cycle that the result side withholds pop

  // Executes one instruction on the shadow state and returns the result word it causes.
  function automatic ty86_pkg::out_word_t execute_instr(input ty86_pkg::in_word_t w);
    ty86_pkg::out_word_t         r;
    logic [7:0]                  nxt;
    logic [7:0]                  a;
    logic [7:0]                  b;
    logic [7:0]                  d;
    int                          addr_sum;
    logic [ty86_pkg::ADDR_W-1:0] addr;
    logic                        over;
    r = '0;
    if (!arch_halted) begin
      nxt      = arch_pc + 8'd1;
      // signed base + signed offset; low 4 bits address the memory, only a
      // positive overrun past the last entry raises the warning
      addr_sum = int'(arch_reg[w.base_reg]) + int'(w.mem_offset);
      addr     = addr_sum[ty86_pkg::ADDR_W-1:0];
      over     = (addr_sum > int'(ty86_pkg::ADDR_SPAN - 1));
      case (w.mode)
        ty86_pkg::OP_HALT: begin
          arch_halted = 1'b1;
          nxt         = arch_pc;
        end
        ty86_pkg::OP_ADD: begin
          r.written_value      = arch_reg[w.dst_reg] + arch_reg[w.src_reg];
          arch_reg[w.dst_reg]  = r.written_value;
        end
        ty86_pkg::OP_SUB: begin
          r.written_value      = arch_reg[w.dst_reg] - arch_reg[w.src_reg];
          arch_reg[w.dst_reg]  = r.written_value;
        end
        ty86_pkg::OP_CMP: begin
          // flags of dst - src; OF is plain signed-subtraction overflow
          a       = arch_reg[w.dst_reg];
          b       = arch_reg[w.src_reg];
          d       = a - b;
          arch_zf = (d == 8'd0);
          arch_sf = d[7];
          arch_of = (a[7] ^ b[7]) & (a[7] ^ d[7]);
        end
        ty86_pkg::OP_JE:  if (arch_zf) nxt = w.branch_target;
        ty86_pkg::OP_JNE: if (!arch_zf) nxt = w.branch_target;
        ty86_pkg::OP_JG:  if (!(arch_sf ^ arch_of) && !arch_zf) nxt = w.branch_target;
        ty86_pkg::OP_JL:  if (arch_sf ^ arch_of) nxt = w.branch_target;
        ty86_pkg::OP_RRMOV: begin
          r.written_value     = arch_reg[w.src_reg];
          arch_reg[w.dst_reg] = r.written_value;
        end
        ty86_pkg::OP_IRMOV: begin
          r.written_value     = w.immediate;
          arch_reg[w.dst_reg] = r.written_value;
        end
        ty86_pkg::OP_RMMOV: begin
          r.written_value   = arch_reg[w.src_reg];
          arch_mem[addr]    = r.written_value;
          r.address_warning = over;
        end
        ty86_pkg::OP_MRMOV: begin
          r.written_value     = arch_mem[addr];
          arch_reg[w.dst_reg] = r.written_value;
          r.address_warning   = over;
        end
        default: begin
          // illegal opcode halts like OP_HALT and flags the fault once
          arch_halted = 1'b1;
          r.fault     = 1'b1;
          nxt         = arch_pc;
        end
      endcase
      arch_pc = nxt;
    end
    // once halted nothing moves: the word just reports the frozen state
    r.next_pc       = arch_pc;
    r.halted        = arch_halted;
    r.zero_flag     = arch_zf;
    r.sign_flag     = arch_sf;
    r.overflow_flag = arch_of;
    return r;
  endfunction

  function automatic ty86_pkg::in_word_t make_instr(input ty86_pkg::op_t op,
                                                    input logic [2:0] src,
                                                    input logic [2:0] dst,
                                                    input logic signed [7:0] imm,
                                                    input logic [2:0] base,
                                                    input logic signed [7:0] off,
                                                    input logic [7:0] tgt);
    ty86_pkg::in_word_t w;
    w.mode          = op;
    w.src_reg       = src;
    w.dst_reg       = dst;
    w.immediate     = imm;
    w.base_reg      = base;
    w.mem_offset    = off;
    w.branch_target = tgt;
    return w;
  endfunction

  // Random operands around a chosen opcode; about half the offsets are small so
  // that addresses land near the real memory, the rest span the full 8-bit range.
  function automatic ty86_pkg::in_word_t random_instr(input logic [3:0] mode);
    ty86_pkg::in_word_t w;
    w.mode          = mode;
    w.src_reg       = 3'($urandom);
    w.dst_reg       = 3'($urandom);
    w.immediate     = 8'($urandom);
    w.base_reg      = 3'($urandom);
    w.mem_offset    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40) - 20)
                                                  : 8'($urandom);
    w.branch_target = 8'($urandom);
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic send_instr(input ty86_pkg::in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    pending_results.push_back(execute_instr(w));
    @(negedge clk);
  endtask

  // Result side: pop is redrawn every cycle from the current stall rate
  always @(negedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every accepted result word is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result word: pc=%0d wv=%0d", out_word.next_pc,
                   out_word.written_value);
      end else begin
        ty86_pkg::out_word_t exp_w;
        exp_w = pending_results.pop_front();
        if (out_word !== exp_w) begin
          error_count++;
          if (error_count <= 10) begin
            $write("mismatch: exp pc=%0d h=%0b f=%0b z=%0b s=%0b o=%0b wv=%0d aw=%0b",
                   exp_w.next_pc, exp_w.halted, exp_w.fault, exp_w.zero_flag,
                   exp_w.sign_flag, exp_w.overflow_flag, exp_w.written_value,
                   exp_w.address_warning);
            $display(" | got pc=%0d h=%0b f=%0b z=%0b s=%0b o=%0b wv=%0d aw=%0b",
                     out_word.next_pc, out_word.halted, out_word.fault,
                     out_word.zero_flag, out_word.sign_flag, out_word.overflow_flag,
                     out_word.written_value, out_word.address_warning);
          end
        end
      end
    end
  end

  // Corner cases: value extremes, wrapping arithmetic, compares that give equal,
  // greater and overflow with SF clear and set, each jump taken and not taken,
  // PC wrap past 255, a jump onto the current instruction, memory sums that
  // overrun, go negative, or hit the last entry exactly.
  task automatic test_directed;
    idle_pct  = 0;
    stall_pct = 0;
    send_instr(make_instr(ty86_pkg::OP_IRMOV, 3'd0, 3'd0, 8'sd127, 3'd0, 8'sd0, 8'd0));
    send_instr(make_instr(ty86_pkg::OP_IRMOV, 3'd0, 3'd1, 8'sh80, 3'd0, 8'sd0, 8'd0));
    send_instr(make_instr(ty86_pkg::OP_IRMOV, 3'd0, 3'd2, 8'sd1, 3'd0, 8'sd0, 8'd0));
    send_instr(make_instr(ty86_pkg::OP_IRMOV, 3'd0, 3'd3, -8'sd1, 3'd0, 8'sd0, 8'd0));
    // 127+1 wraps
    send_instr(make_instr(ty86_pkg::OP_ADD, 3'd2, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // -128-1 wraps
    send_instr(make_instr(ty86_pkg::OP_SUB, 3'd2, 3'd1, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // overflow, SF clear
    send_instr(make_instr(ty86_pkg::OP_CMP, 3'd2, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // taken
    send_instr(make_instr(ty86_pkg::OP_JL, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd200));
    // not taken
    send_instr(make_instr(ty86_pkg::OP_JG, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // equal
    send_instr(make_instr(ty86_pkg::OP_CMP, 3'd2, 3'd2, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // to the last PC
    send_instr(make_instr(ty86_pkg::OP_JE, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd255));
    // falls through, PC wraps
    send_instr(make_instr(ty86_pkg::OP_JNE, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd3));
    // 1 - (-1): greater
    send_instr(make_instr(ty86_pkg::OP_CMP, 3'd3, 3'd2, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // onto itself
    send_instr(make_instr(ty86_pkg::OP_JG, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd1));
    send_instr(make_instr(ty86_pkg::OP_JNE, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd100));
    send_instr(make_instr(ty86_pkg::OP_JE, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd5));
    send_instr(make_instr(ty86_pkg::OP_RRMOV, 3'd1, 3'd4, 8'sd0, 3'd0, 8'sd0, 8'd0));
    // 127+127 overruns
    send_instr(make_instr(ty86_pkg::OP_RMMOV, 3'd4, 3'd0, 8'sd0, 3'd4, 8'sd127, 8'd0));
    // negative sum
    send_instr(make_instr(ty86_pkg::OP_MRMOV, 3'd0, 3'd5, 8'sd0, 3'd3, 8'sh80, 8'd0));
    // sum exactly 0
    send_instr(make_instr(ty86_pkg::OP_RMMOV, 3'd1, 3'd0, 8'sd0, 3'd3, 8'sd1, 8'd0));
    // last entry
    send_instr(make_instr(ty86_pkg::OP_MRMOV, 3'd0, 3'd6, 8'sd0, 3'd2, 8'sd14, 8'd0));
    // reads back
    send_instr(make_instr(ty86_pkg::OP_MRMOV, 3'd0, 3'd7, 8'sd0, 3'd2, 8'sd13, 8'd0));
    // one past end
    send_instr(make_instr(ty86_pkg::OP_RMMOV, 3'd7, 3'd0, 8'sd0, 3'd2, 8'sd15, 8'd0));
    // 127 - (-128)
    send_instr(make_instr(ty86_pkg::OP_CMP, 3'd0, 3'd1, 8'sd0, 3'd0, 8'sd0, 8'd0));
    send_instr(make_instr(ty86_pkg::OP_JL, 3'd0, 3'd0, 8'sd0, 3'd0, 8'sd0, 8'd42));
  endtask

  // Random programs of legal opcodes; compares are often followed by a jump so
  // every branch condition sees fresh flags, loads keep the registers varied.
  task automatic test_random(input int count, input int idle, input int stall);
    int n;
    int pick;
    idle_pct  = idle;
    stall_pct = stall;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_instr(random_instr(ty86_pkg::OP_CMP));
        send_instr(random_instr(4'($urandom_range(ty86_pkg::OP_JE, ty86_pkg::OP_JL))));
        n += 2;
      end else begin
        if (pick < 40)
          send_instr(random_instr(ty86_pkg::OP_IRMOV));
        else
          send_instr(random_instr(4'($urandom_range(ty86_pkg::OP_ADD,
                                                    ty86_pkg::OP_MRMOV))));
        n++;
      end
    end
  endtask

  // Stops the machine with halt or an illegal opcode, then checks that any
  // further word, legal or not, only reports the frozen state.
  task automatic test_halted;
    idle_pct  = 27;
    stall_pct = 27;
    if ($urandom_range(0, 1) == 0)
      send_instr(random_instr(ty86_pkg::OP_HALT));
    else
      send_instr(random_instr(4'($urandom_range(ty86_pkg::OP_BAD, 15))));
    repeat (30) send_instr(random_instr(4'($urandom)));
  endtask

  // Runaway guard: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    error_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_word     = '0;
    out_pop     = 1'b0;
    arch_pc     = '0;
    arch_zf     = 1'b0;
    arch_sf     = 1'b0;
    arch_of     = 1'b0;
    arch_halted = 1'b0;
    foreach (arch_reg[i]) arch_reg[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(150, 0, 0);
    test_random(150, 73, 0);
    test_random(150, 0, 73);
    test_random(150, 27, 27);
    test_halted();

    // drain: let the result side run free until every prediction is matched
    in_push   <= 1'b0;
    stall_pct  = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ty86_pkg.sv
rtl/core/ty86_front.sv
rtl/core/ty86_back.sv
rtl/core/tiny_y86_subset_execute.sv
tb/tiny_y86_subset_execute_test.sv
